// ===== rtl/core/o2q_pkg.sv =====
package o2q_pkg;

  localparam logic [1:0] TAG_CONIC = 2'd0;
  localparam logic [1:0] TAG_CUBIC = 2'd2;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic first;
    logic second;
  } o2q_push_t;

endpackage

// ===== rtl/core/o2q_if.sv =====
interface o2q_point_if #(parameter int W = 24);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] point_x;
  logic signed [W-1:0] point_y;
  logic [1:0]          point_tag;
  logic                contour_end;
  logic                glyph_end;

  modport source (output valid, point_x, point_y, point_tag, contour_end, glyph_end,
                  input ready);
  modport sink (input valid, point_x, point_y, point_tag, contour_end, glyph_end,
                output ready);
endinterface

interface o2q_seg_if #(parameter int W = 24);
  logic              valid;
  logic              ready;
  logic signed [W:0] start_x;
  logic signed [W:0] start_y;
  logic signed [W:0] control_x;
  logic signed [W:0] control_y;
  logic signed [W:0] finish_x;
  logic signed [W:0] finish_y;
  logic signed [W-1:0] box_left;
  logic signed [W:0]   box_bottom;
  logic [W-2:0]        box_right;
  logic [W-1:0]        box_top;
  logic                closes_contour;
  logic                closes_glyph;

  modport source (output valid, start_x, start_y, control_x, control_y, finish_x, finish_y,
                  box_left, box_bottom, box_right, box_top, closes_contour, closes_glyph,
                  input ready);
  modport sink (input valid, start_x, start_y, control_x, control_y, finish_x, finish_y,
                box_left, box_bottom, box_right, box_top, closes_contour, closes_glyph,
                output ready);
endinterface

// ===== rtl/core/o2q_outq.sv =====
module o2q_outq #(
  parameter int DATA_W = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  o2q_pkg::o2q_push_t push,
  input  logic [DATA_W-1:0]  wr_data0,
  input  logic [DATA_W-1:0]  wr_data1,
  output logic               wr_ready,
  output logic               rd_valid,
  input  logic               rd_ready,
  output logic [DATA_W-1:0]  rd_data
);
  import o2q_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] q_r [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     cnt_nxt;
  logic              pop;

  assign pop      = rd_valid && rd_ready;
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = q_r[rd_ptr_r];
  assign wr_ready = (cnt_r <= CW'(QUEUE_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push.first) + PW'(push.second);
    cnt_nxt    = cnt_r + CW'(push.first) + CW'(push.second) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      q_r[wr_ptr_r] <= wr_data0;
    end
    if (push.second) begin
      q_r[wr_ptr_r + PW'(1)] <= wr_data1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.second |-> push.first)
    else $error("second request pushed without first");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push.first && !push.second && !pop) |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("queue count lost a request");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointer gap");

endmodule

// ===== rtl/core/outline_to_quadratic_segments.sv =====
// Outline point to quadratic segment converter.
// in_point carries one outline point per request (valid/ready): signed
// coordinates, a two-bit tag, and end-of-contour and end-of-glyph marks.
// out_seg carries quadratic segments (start, control, finish), all at twice
// the coordinate, plus the running bounding box and close flags.
// A point is taken in any cycle that in_point.ready is high, one per clock.
// Its segments (none, one or two) are written into the result queue when the
// point is accepted and reach out_seg from the head of the queue; a point that
// both completes a curve and ends its contour yields two segments, curve first.
// Results pass through a four-entry result queue; in_point.ready stays high
// while the queue has room for two segments, so a stalled receiver holds
// the input back only once three or more segments are waiting.
// Reset empties the queue, drops any open contour and clears the box to the
// origin; the box also clears after each end-of-glyph point.
module outline_to_quadratic_segments #(
  parameter int COORD_BITS = 24
) (
  input  logic clk,
  input  logic rst_n,
  o2q_point_if.sink in_point,
  o2q_seg_if.source out_seg
);
  import o2q_pkg::*;

  localparam int W  = COORD_BITS;
  localparam int DW = COORD_BITS + 1;
  localparam int SW = COORD_BITS + 2;
  localparam int RW = 6 * DW + W + DW + (W - 1) + W + 2;

  function automatic logic signed [DW-1:0] mid2(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b);
    logic signed [SW-1:0] s;
    s = SW'(a) + SW'(b);
    s = s + $signed(SW'(s[SW-1]));
    return DW'(s >>> 1);
  endfunction

  logic signed [DW-1:0] h0x_r, h0y_r, h1x_r, h1y_r, fx_r, fy_r;
  logic signed [DW-1:0] h0x_nxt, h0y_nxt, h1x_nxt, h1y_nxt, fx_nxt, fy_nxt;
  logic                 have_first_r, have_first_nxt;
  logic                 in_conic_r, in_conic_nxt;
  logic signed [W-1:0]  min_x_r, min_x_nxt, max_x_r, max_x_nxt;
  logic signed [DW-1:0] min_y_r, max_y_r;
  logic signed [DW-1:0] cmin_y_r, cmin_y_nxt, cmax_y_r, cmax_y_nxt;
  logic signed [DW-1:0] bot, top;

  logic                 in_fire, closing, glyph_end, non_cubic;
  logic signed [W-1:0]  px, py;
  logic signed [DW-1:0] ye, dx, dy;
  logic signed [DW-1:0] mid_cx, mid_cy, mid_lx, mid_ly, mid_ex, mid_ey;

  logic                 step_v, close_v;
  logic signed [DW-1:0] step_cx, step_cy, step_fx, step_fy;
  logic signed [DW-1:0] close_sx, close_sy, close_cx, close_cy;

  logic [RW-1:0]        wr_data0, wr_data1, rd_data;
  logic [4*W-1:0]       box_bits;
  o2q_push_t            push;
  logic                 q_ready;

  assign in_fire   = in_point.valid && in_point.ready;
  assign in_point.ready = q_ready;
  assign px        = in_point.point_x;
  assign py        = in_point.point_y;
  assign glyph_end = in_point.glyph_end;
  assign closing   = in_point.contour_end || in_point.glyph_end;
  assign non_cubic = (in_point.point_tag != TAG_CUBIC);
  assign dx        = $signed({px, 1'b0});
  assign dy        = $signed({py, 1'b0});
  assign ye        = DW'(py);

  assign mid_cx = mid2(h1x_r, dx);
  assign mid_cy = mid2(h1y_r, dy);
  assign mid_lx = mid2(h0x_r, dx);
  assign mid_ly = mid2(h0y_r, dy);
  assign mid_ex = mid2(non_cubic ? dx : h0x_r, have_first_r ? fx_r : dx);
  assign mid_ey = mid2(non_cubic ? dy : h0y_r, have_first_r ? fy_r : dy);

  always_comb begin
    min_x_nxt  = (px < min_x_r) ? px : min_x_r;
    max_x_nxt  = (px > max_x_r) ? px : max_x_r;
    cmin_y_nxt = (ye < cmin_y_r) ? ye - DW'(1) : cmin_y_r;
    cmax_y_nxt = (ye > cmax_y_r) ? ye + DW'(1) : cmax_y_r;
    bot        = (cmin_y_nxt < min_y_r) ? cmin_y_nxt : min_y_r;
    top        = (cmax_y_nxt > max_y_r) ? cmax_y_nxt : max_y_r;
  end

  always_comb begin
    h0x_nxt        = h0x_r;
    h0y_nxt        = h0y_r;
    h1x_nxt        = h1x_r;
    h1y_nxt        = h1y_r;
    fx_nxt         = fx_r;
    fy_nxt         = fy_r;
    have_first_nxt = have_first_r;
    in_conic_nxt   = in_conic_r;
    step_v         = 1'b0;
    step_cx        = h1x_r;
    step_cy        = h1y_r;
    step_fx        = dx;
    step_fy        = dy;
    if (non_cubic) begin
      if (!have_first_r) begin
        h0x_nxt        = dx;
        h0y_nxt        = dy;
        fx_nxt         = dx;
        fy_nxt         = dy;
        have_first_nxt = 1'b1;
        in_conic_nxt   = 1'b0;
      end else if (in_point.point_tag == TAG_CONIC) begin
        if (in_conic_r) begin
          step_v  = 1'b1;
          step_fx = mid_cx;
          step_fy = mid_cy;
          h0x_nxt = mid_cx;
          h0y_nxt = mid_cy;
        end
        h1x_nxt      = dx;
        h1y_nxt      = dy;
        in_conic_nxt = 1'b1;
      end else begin
        step_v       = 1'b1;
        step_cx      = in_conic_r ? h1x_r : mid_lx;
        step_cy      = in_conic_r ? h1y_r : mid_ly;
        h0x_nxt      = dx;
        h0y_nxt      = dy;
        in_conic_nxt = 1'b0;
      end
    end
    close_v  = closing && have_first_nxt;
    close_sx = h0x_nxt;
    close_sy = h0y_nxt;
    close_cx = in_conic_nxt ? h1x_nxt : mid_ex;
    close_cy = in_conic_nxt ? h1y_nxt : mid_ey;
    if (closing) begin
      have_first_nxt = 1'b0;
      in_conic_nxt   = 1'b0;
    end
  end

  always_comb begin
    box_bits = {min_x_nxt, bot, max_x_nxt[W-2:0], top[W-1:0]};
    wr_data1 = {close_sx, close_sy, close_cx, close_cy, fx_nxt, fy_nxt,
                box_bits, 1'b1, glyph_end};
    if (step_v) begin
      wr_data0 = {h0x_r, h0y_r, step_cx, step_cy, step_fx, step_fy,
                  box_bits, 1'b0, 1'b0};
    end else begin
      wr_data0 = wr_data1;
    end
    push.first  = in_fire && (step_v || close_v);
    push.second = in_fire && step_v && close_v;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      h0x_r <= h0x_nxt;
      h0y_r <= h0y_nxt;
      h1x_r <= h1x_nxt;
      h1y_r <= h1y_nxt;
      fx_r  <= fx_nxt;
      fy_r  <= fy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_first_r <= 1'b0;
      in_conic_r   <= 1'b0;
      min_x_r      <= '0;
      max_x_r      <= '0;
      min_y_r      <= '0;
      max_y_r      <= '0;
      cmin_y_r     <= '0;
      cmax_y_r     <= '0;
    end else if (in_fire) begin
      have_first_r <= have_first_nxt;
      in_conic_r   <= in_conic_nxt;
      min_x_r      <= glyph_end ? '0 : min_x_nxt;
      max_x_r      <= glyph_end ? '0 : max_x_nxt;
      min_y_r      <= glyph_end ? '0 : (closing ? bot : min_y_r);
      max_y_r      <= glyph_end ? '0 : (closing ? top : max_y_r);
      cmin_y_r     <= closing ? '0 : cmin_y_nxt;
      cmax_y_r     <= closing ? '0 : cmax_y_nxt;
    end
  end

  o2q_outq #(
    .DATA_W (RW)
  ) u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_data0 (wr_data0),
    .wr_data1 (wr_data1),
    .wr_ready (q_ready),
    .rd_valid (out_seg.valid),
    .rd_ready (out_seg.ready),
    .rd_data  (rd_data)
  );

  assign {out_seg.start_x, out_seg.start_y, out_seg.control_x, out_seg.control_y,
          out_seg.finish_x, out_seg.finish_y, out_seg.box_left, out_seg.box_bottom,
          out_seg.box_right, out_seg.box_top, out_seg.closes_contour,
          out_seg.closes_glyph} = rd_data;

  a_conic_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_conic_r |-> have_first_r)
    else $error("conic run without a start point");

  a_close_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && closing) |=> (!have_first_r && cmin_y_r == '0 && cmax_y_r == '0))
    else $error("contour state survived its end");

  a_glyph_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && glyph_end) |=>
      (min_x_r == '0 && max_x_r == '0 && min_y_r == '0 && max_y_r == '0))
    else $error("box not cleared after glyph end");

  a_box_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (min_x_r <= $signed(W'(0)) && max_x_r >= $signed(W'(0)) &&
     min_y_r <= $signed(DW'(0)) && max_y_r >= $signed(DW'(0))))
    else $error("box lost the origin");

endmodule
